>>> src/pdlc_pkg.sv
// Package for the password door lock controller: item types, codes and constants.
`default_nettype none
package pdlc_pkg;

    localparam int PW_LEN   = 6;
    localparam int PW_POS_W = (PW_LEN > 1) ? $clog2(PW_LEN) : 1;
    localparam int PW_W     = 8 * PW_LEN;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 64;

    localparam logic [1:0] CFG_INIT_PW   = 2'd0;
    localparam logic [1:0] CFG_MAX_TRIES = 2'd1;
    localparam logic [1:0] CFG_TRAVEL    = 2'd2;
    localparam logic [1:0] CFG_CYCLE     = 2'd3;

    localparam logic [PW_W-1:0] INIT_PW_RST   = PW_W'(64'd54091677185334);
    localparam logic [7:0]      MAX_TRIES_RST = 8'd3;
    localparam logic [3:0]      TRAVEL_RST    = 4'd3;
    localparam logic [3:0]      CYCLE_RST     = 4'd10;

    localparam logic [7:0] CHAR_ENTER = 8'h65;  // 'e'
    localparam logic [7:0] CHAR_CHECK = 8'h63;  // 'c'
    localparam logic [7:0] CHAR_SET   = 8'h73;  // 's'
    localparam logic [7:0] CHAR_YES   = 8'h59;  // 'Y'
    localparam logic [7:0] CHAR_NO    = 8'h4E;  // 'N'
    localparam logic [7:0] CHAR_OK    = 8'h4B;  // 'K'

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [1:0] MOTOR_STOP  = 2'd0;
    localparam logic [1:0] MOTOR_OPEN  = 2'd1;
    localparam logic [1:0] MOTOR_CLOSE = 2'd2;

    typedef enum logic [3:0] {
        MODE_NONE  = 4'b0001,
        MODE_ENTER = 4'b0010,
        MODE_CHECK = 4'b0100,
        MODE_SET   = 4'b1000
    } t_mode;

    typedef struct packed {
        logic       operation;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic       reply_valid;
        logic [7:0] reply_byte;
        logic [1:0] motor_drive;
        logic       buzzer_on;
    } t_out_item;

endpackage
`default_nettype wire

>>> src/password_door_lock_controller.sv
// Top level of the password door lock controller.
`default_nettype none
// Takes one item per clock: a received serial byte or a one-second tick. The
// item is decoded, compared against the stored password and applied to the
// door timer combinationally, and its result item appears in the output
// register on the next cycle, so the sustained rate is one item per cycle
// while the receiver does not stall. The input side stalls only while a
// finished result sits in the output register and the receiver stalls it.
// Bytes e, c and s pick enter, check and set; six other bytes complete a
// password. APB registers: 0x00 (initial password, read back only; reset
// loads a fixed default), 0x08 (max tries), 0x10/0x18 (travel/cycle ticks).
module password_door_lock_controller (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_in_valid,
    output logic                                 o_in_stall,
    input  wire  pdlc_pkg::t_in_item             i_in_data,
    output logic                                 o_out_valid,
    input  wire                                  i_out_stall,
    output pdlc_pkg::t_out_item                  o_out_data,
    input  wire                                  psel,
    input  wire                                  penable,
    input  wire                                  pwrite,
    input  wire  [pdlc_pkg::CFG_ADDR_W-1:0]      paddr,
    input  wire  [pdlc_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [pdlc_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                 pready
);

    typedef logic [7:0] t_byte;

    logic [pdlc_pkg::PW_W-1:0] r_init_pw;
    logic [7:0]                r_max_tries;
    logic [3:0]                r_travel;
    logic [3:0]                r_cycle;

    pdlc_pkg::t_mode              r_mode, n_mode;
    logic [pdlc_pkg::PW_POS_W-1:0] r_pos, n_pos;
    t_byte                         r_entered [pdlc_pkg::PW_LEN];
    t_byte                         r_stored  [pdlc_pkg::PW_LEN];
    logic [7:0]                    r_fails, n_fails;
    logic                          r_buzz, n_buzz;
    logic                          r_run, n_run;
    logic [3:0]                    r_cnt, n_cnt;
    logic                          r_closing, n_closing;
    logic [1:0]                    r_motor, n_motor;

    logic                 r_out_valid;
    pdlc_pkg::t_out_item  r_out_data, n_out_data;

    logic                 accept;
    logic                 cfg_wr;
    logic [1:0]           cfg_idx;
    logic                 store_byte;
    logic                 last_byte;
    logic                 do_set;
    t_byte                cand [pdlc_pkg::PW_LEN];

    assign pready     = 1'b1;
    assign cfg_wr     = psel & penable & pwrite;
    assign cfg_idx    = paddr[pdlc_pkg::CFG_ADDR_W-1:3];
    assign o_in_stall = r_out_valid & i_out_stall;
    assign accept     = i_in_valid & ~o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        case (cfg_idx)
            pdlc_pkg::CFG_INIT_PW:   prdata = pdlc_pkg::CFG_DATA_W'(r_init_pw);
            pdlc_pkg::CFG_MAX_TRIES: prdata = pdlc_pkg::CFG_DATA_W'(r_max_tries);
            pdlc_pkg::CFG_TRAVEL:    prdata = pdlc_pkg::CFG_DATA_W'(r_travel);
            pdlc_pkg::CFG_CYCLE:     prdata = pdlc_pkg::CFG_DATA_W'(r_cycle);
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_pw   <= pdlc_pkg::INIT_PW_RST;
            r_max_tries <= pdlc_pkg::MAX_TRIES_RST;
            r_travel    <= pdlc_pkg::TRAVEL_RST;
            r_cycle     <= pdlc_pkg::CYCLE_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                pdlc_pkg::CFG_INIT_PW:   r_init_pw   <= pwdata[pdlc_pkg::PW_W-1:0];
                pdlc_pkg::CFG_MAX_TRIES: r_max_tries <= pwdata[7:0];
                pdlc_pkg::CFG_TRAVEL:    r_travel    <= pwdata[3:0];
                pdlc_pkg::CFG_CYCLE:     r_cycle     <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        logic       is_cmd;
        logic       match;
        logic [3:0] cnt_inc;

        n_mode    = r_mode;
        n_pos     = r_pos;
        n_fails   = r_fails;
        n_buzz    = r_buzz;
        n_run     = r_run;
        n_cnt     = r_cnt;
        n_closing = r_closing;
        n_motor   = r_motor;
        store_byte = 1'b0;
        last_byte  = 1'b0;
        do_set     = 1'b0;
        n_out_data = '0;
        is_cmd     = 1'b1;
        cnt_inc    = r_cnt + 4'd1;

        // Compare against the entry with the incoming byte dropped into its slot
        match = 1'b1;
        for (int i = 0; i < pdlc_pkg::PW_LEN; i++) begin
            cand[i] = (r_pos == pdlc_pkg::PW_POS_W'(i)) ? i_in_data.rx_byte : r_entered[i];
            if (cand[i] != r_stored[i]) match = 1'b0;
        end

        if (i_in_data.operation == pdlc_pkg::OP_TICK) begin
            if (r_run) begin
                n_cnt = cnt_inc;
                if (cnt_inc == r_cycle) begin
                    n_motor   = pdlc_pkg::MOTOR_CLOSE;
                    n_cnt     = 4'd0;
                    n_closing = 1'b1;
                end else if (cnt_inc == r_travel) begin
                    n_motor = pdlc_pkg::MOTOR_STOP;
                    if (r_closing) n_run = 1'b0;
                end
            end
        end else begin
            if (i_in_data.rx_byte == pdlc_pkg::CHAR_ENTER)      n_mode = pdlc_pkg::MODE_ENTER;
            else if (i_in_data.rx_byte == pdlc_pkg::CHAR_CHECK) n_mode = pdlc_pkg::MODE_CHECK;
            else if (i_in_data.rx_byte == pdlc_pkg::CHAR_SET)   n_mode = pdlc_pkg::MODE_SET;
            else is_cmd = 1'b0;

            if (!is_cmd && r_mode != pdlc_pkg::MODE_NONE) begin
                store_byte = 1'b1;
                last_byte  = (r_pos == pdlc_pkg::PW_POS_W'(pdlc_pkg::PW_LEN - 1));
                n_pos      = last_byte ? '0 : r_pos + 1'b1;
                if (last_byte) begin
                    if (r_mode == pdlc_pkg::MODE_SET) begin
                        do_set = 1'b1;
                    end else begin
                        n_out_data.reply_valid = 1'b1;
                        if (match) begin
                            n_fails = 8'd0;
                            n_buzz  = 1'b0;
                            if (r_mode == pdlc_pkg::MODE_ENTER) begin
                                n_out_data.reply_byte = pdlc_pkg::CHAR_YES;
                                n_motor   = pdlc_pkg::MOTOR_OPEN;
                                n_run     = 1'b1;
                                n_cnt     = 4'd0;
                                n_closing = 1'b0;
                            end else begin
                                n_out_data.reply_byte = pdlc_pkg::CHAR_OK;
                            end
                        end else begin
                            n_out_data.reply_byte = pdlc_pkg::CHAR_NO;
                            if (r_fails != 8'hFF) n_fails = r_fails + 8'd1;
                            if (n_fails == r_max_tries) n_buzz = 1'b1;
                        end
                    end
                end
            end
        end

        n_out_data.motor_drive = n_motor;
        n_out_data.buzzer_on   = n_buzz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= pdlc_pkg::MODE_NONE;
            r_pos     <= '0;
            r_fails   <= 8'd0;
            r_buzz    <= 1'b0;
            r_run     <= 1'b0;
            r_cnt     <= 4'd0;
            r_closing <= 1'b0;
            r_motor   <= pdlc_pkg::MOTOR_STOP;
            for (int i = 0; i < pdlc_pkg::PW_LEN; i++) begin
                r_stored[i] <= pdlc_pkg::INIT_PW_RST[8*(pdlc_pkg::PW_LEN-1-i) +: 8];
            end
        end else if (accept) begin
            r_mode    <= n_mode;
            r_pos     <= n_pos;
            r_fails   <= n_fails;
            r_buzz    <= n_buzz;
            r_run     <= n_run;
            r_cnt     <= n_cnt;
            r_closing <= n_closing;
            r_motor   <= n_motor;
            if (do_set) begin
                for (int i = 0; i < pdlc_pkg::PW_LEN; i++) r_stored[i] <= cand[i];
            end
        end
    end

    // Entry bytes hold no reset; only written slots are ever compared
    always_ff @(posedge i_clk) begin
        if (accept && store_byte) begin
            for (int i = 0; i < pdlc_pkg::PW_LEN; i++) begin
                if (r_pos == pdlc_pkg::PW_POS_W'(i)) r_entered[i] <= i_in_data.rx_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_out_data <= n_out_data;
    end

endmodule
`default_nettype wire

>>> src/pdlc_checker.sv
// Port-level checks for the password door lock controller, bound to the top level.
`default_nettype none
module pdlc_checker (
    input wire                   i_clk,
    input wire                   i_rst_n,
    input wire                   i_in_valid,
    input wire                   o_in_stall,
    input wire                   o_out_valid,
    input wire                   i_out_stall,
    input wire pdlc_pkg::t_out_item o_out_data
);

    // Stall the input only when a result is held back
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a held result");

    // Every accepted item produces a result on the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("accepted item produced no result");

    a_reply_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.reply_valid
            ? (o_out_data.reply_byte == pdlc_pkg::CHAR_YES ||
               o_out_data.reply_byte == pdlc_pkg::CHAR_OK ||
               o_out_data.reply_byte == pdlc_pkg::CHAR_NO)
            : (o_out_data.reply_byte == 8'd0)))
        else $error("bad reply byte");

    a_motor_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.motor_drive == pdlc_pkg::MOTOR_STOP ||
                         o_out_data.motor_drive == pdlc_pkg::MOTOR_OPEN ||
                         o_out_data.motor_drive == pdlc_pkg::MOTOR_CLOSE))
        else $error("bad motor drive code");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

endmodule

bind password_door_lock_controller pdlc_checker u_pdlc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
`default_nettype wire

>>> tb/password_door_lock_controller_test.sv
// Self-checking testbench for the password door lock controller.
`default_nettype none
module password_door_lock_controller_test;
    import pdlc_pkg::*;

    localparam int LONG_HOLD      = 80;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;
    localparam t_out_item QUIET   = {1'b0, 8'h00, MOTOR_STOP, 1'b0};
    localparam t_out_item DENIED  = {1'b1, CHAR_NO, MOTOR_STOP, 1'b0};

    typedef struct packed {
        logic      known;
        t_in_item  item;
        t_out_item want;
    } t_dir_row;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    t_in_item              i_in_data   = '0;
    logic                  i_out_stall = 1'b0;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr       = '0;
    logic [CFG_DATA_W-1:0] pwdata      = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out_item             o_out_data;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // lock model state
    t_mode                      pw_mode      = MODE_NONE;
    logic [PW_POS_W-1:0]        pw_pos       = '0;
    logic [PW_LEN-1:0][7:0]     typed_pw     = '0;
    logic [PW_LEN-1:0][7:0]     saved_pw     = INIT_PW_RST;
    logic [7:0]                 miss_count   = '0;
    logic                       alarm        = 1'b0;
    logic                       timer_on     = 1'b0;
    logic [3:0]                 door_ticks   = '0;
    logic                       door_shutting = 1'b0;
    logic [1:0]                 motor_dir    = MOTOR_STOP;
    logic [7:0]                 max_tries_cfg = MAX_TRIES_RST;
    logic [3:0]                 travel_cfg   = TRAVEL_RST;
    logic [3:0]                 cycle_cfg    = CYCLE_RST;

    t_out_item lock_out_q[$];
    t_dir_row  dir_tbl[0:24];
    int        errors       = 0;
    int        tx_idle_pct  = 0;
    int        rx_idle_pct  = 0;
    int        hold_req     = 0;
    int        hold_seen    = 0;
    int        hold_left    = 0;
    int        quiet_cycles = 0;

    password_door_lock_controller uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_out_item lock_step(input t_in_item it);
        t_out_item res;
        logic      cmd_byte;
        res = '0;
        if (it.operation == OP_TICK) begin
            if (timer_on) begin
                door_ticks = door_ticks + 4'd1;
                // cycle end wins over travel end when both match
                if (door_ticks == cycle_cfg) begin
                    motor_dir     = MOTOR_CLOSE;
                    door_ticks    = '0;
                    door_shutting = 1'b1;
                end else if (door_ticks == travel_cfg) begin
                    motor_dir = MOTOR_STOP;
                    if (door_shutting)
                        timer_on = 1'b0;
                end
            end
        end else begin
            cmd_byte = 1'b1;
            case (it.rx_byte)
                CHAR_ENTER: pw_mode = MODE_ENTER;
                CHAR_CHECK: pw_mode = MODE_CHECK;
                CHAR_SET:   pw_mode = MODE_SET;
                default:    cmd_byte = 1'b0;
            endcase
            if (pw_mode != MODE_NONE && !cmd_byte) begin
                typed_pw[PW_LEN-1-pw_pos] = it.rx_byte;
                if (pw_pos == PW_POS_W'(PW_LEN-1)) begin
                    pw_pos = '0;
                    if (pw_mode == MODE_SET) begin
                        saved_pw = typed_pw;
                    end else begin
                        res.reply_valid = 1'b1;
                        if (typed_pw == saved_pw) begin
                            miss_count = '0;
                            alarm      = 1'b0;
                            if (pw_mode == MODE_ENTER) begin
                                motor_dir     = MOTOR_OPEN;
                                timer_on      = 1'b1;
                                door_ticks    = '0;
                                door_shutting = 1'b0;
                                res.reply_byte = CHAR_YES;
                            end else begin
                                res.reply_byte = CHAR_OK;
                            end
                        end else begin
                            if (miss_count != 8'hFF)
                                miss_count = miss_count + 8'd1;
                            if (miss_count == max_tries_cfg)
                                alarm = 1'b1;
                            res.reply_byte = CHAR_NO;
                        end
                    end
                end else begin
                    pw_pos = pw_pos + 1'b1;
                end
            end
        end
        res.motor_drive = motor_dir;
        res.buzzer_on   = alarm;
        return res;
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == CHAR_ENTER || b == CHAR_CHECK || b == CHAR_SET);
        return b;
    endfunction

    task automatic report_field(input string name, input logic [7:0] want_v,
                                input logic [7:0] got_v);
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want_v, got_v);
        errors++;
    endtask

    task automatic send_item(input t_in_item it, input logic known, input t_out_item want);
        t_out_item got;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do
            @(posedge i_clk);
        while (o_in_stall);
        got = lock_step(it);
        lock_out_q.push_back(known ? want : got);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (lock_out_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] value);
        logic [CFG_DATA_W-1:0] rd_want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do
            @(posedge i_clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_INIT_PW: begin
                // initial password is read back only; stored one is unchanged
                rd_want = CFG_DATA_W'(value[PW_W-1:0]);
            end
            CFG_MAX_TRIES: begin
                max_tries_cfg = value[7:0];
                rd_want       = CFG_DATA_W'(value[7:0]);
            end
            CFG_TRAVEL: begin
                travel_cfg = value[3:0];
                rd_want    = CFG_DATA_W'(value[3:0]);
            end
            CFG_CYCLE: begin
                cycle_cfg = value[3:0];
                rd_want   = CFG_DATA_W'(value[3:0]);
            end
            default: rd_want = '0;
        endcase
        if (prdata !== rd_want) begin
            $display("%0t: register readback mismatch, expected %0h actual %0h",
                     $time, rd_want, prdata);
            errors++;
        end
    endtask

    task automatic run_random(input int n_items);
        int         sent;
        int         pick;
        int         bad_pos;
        int         burst;
        logic [7:0] cmd;
        logic [7:0] b;
        logic [7:0] good;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                // command letter, then enough bytes to finish the password
                if (pick < 12)
                    cmd = CHAR_SET;
                else if (pick < 38)
                    cmd = CHAR_ENTER;
                else
                    cmd = CHAR_CHECK;
                send_item({OP_BYTE, cmd}, 1'b0, QUIET);
                sent++;
                bad_pos = ($urandom_range(99) < 55) ? -1 : int'($urandom_range(PW_LEN-1));
                do begin
                    if (cmd == CHAR_SET) begin
                        b = plain_byte();
                    end else begin
                        good = saved_pw[PW_LEN-1-pw_pos];
                        b    = good;
                        if (int'(pw_pos) == bad_pos) begin
                            do
                                b = plain_byte();
                            while (b == good);
                        end
                    end
                    send_item({OP_BYTE, b}, 1'b0, QUIET);
                    sent++;
                end while (pw_pos != 0);
            end else if (pick < 85) begin
                burst = $urandom_range(16, 1);
                repeat (burst) begin
                    send_item({OP_TICK, 8'($urandom_range(255))}, 1'b0, QUIET);
                    sent++;
                end
            end else begin
                burst = $urandom_range(3, 1);
                repeat (burst) begin
                    send_item({OP_BYTE, 8'($urandom_range(255))}, 1'b0, QUIET);
                    sent++;
                end
            end
        end
    endtask

    task automatic run_phase(input logic [7:0] max_t, input logic [3:0] trav,
                             input logic [3:0] cyc, input logic [PW_W-1:0] init_pw,
                             input int tx_pct, input int rx_pct, input int n_items);
        wait_idle();
        cfg_write(CFG_INIT_PW, CFG_DATA_W'(init_pw));
        cfg_write(CFG_MAX_TRIES, CFG_DATA_W'(max_t));
        cfg_write(CFG_TRAVEL, CFG_DATA_W'(trav));
        cfg_write(CFG_CYCLE, CFG_DATA_W'(cyc));
        tx_idle_pct = tx_pct;
        rx_idle_pct <= rx_pct;
        run_random(n_items);
    endtask

    always @(posedge i_clk) begin : result_side
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (lock_out_q.size() == 0) begin
                $display("%0t: result with none expected, expected none actual %h",
                         $time, o_out_data);
                errors++;
            end else begin
                want = lock_out_q.pop_front();
                if (want.reply_valid !== o_out_data.reply_valid)
                    report_field("reply_valid", 8'(want.reply_valid),
                                 8'(o_out_data.reply_valid));
                if (want.reply_byte !== o_out_data.reply_byte)
                    report_field("reply_byte", want.reply_byte, o_out_data.reply_byte);
                if (want.motor_drive !== o_out_data.motor_drive)
                    report_field("motor_drive", 8'(want.motor_drive),
                                 8'(o_out_data.motor_drive));
                if (want.buzzer_on !== o_out_data.buzzer_on)
                    report_field("buzzer_on", 8'(want.buzzer_on), 8'(o_out_data.buzzer_on));
            end
        end
        if (hold_seen != hold_req) begin
            hold_seen   <= hold_req;
            hold_left   <= LONG_HOLD;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[password_door_lock_controller] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int         k;
        logic [3:0] trav;
        // stored password after the first row of sets: FF 32 33 34 35 00
        dir_tbl[0]  = {1'b1, OP_TICK, 8'h5A, QUIET};       // tick with door idle
        dir_tbl[1]  = {1'b1, OP_BYTE, 8'h00, QUIET};       // byte before any command
        dir_tbl[2]  = {1'b1, OP_BYTE, CHAR_SET, QUIET};
        dir_tbl[3]  = {1'b1, OP_BYTE, 8'hFF, QUIET};
        dir_tbl[4]  = {1'b1, OP_BYTE, 8'h32, QUIET};
        dir_tbl[5]  = {1'b1, OP_BYTE, 8'h33, QUIET};
        dir_tbl[6]  = {1'b1, OP_BYTE, 8'h34, QUIET};
        dir_tbl[7]  = {1'b1, OP_BYTE, 8'h35, QUIET};
        dir_tbl[8]  = {1'b1, OP_BYTE, 8'h00, QUIET};
        dir_tbl[9]  = {1'b1, OP_BYTE, CHAR_CHECK, QUIET};
        dir_tbl[10] = {1'b1, OP_BYTE, 8'h31, QUIET};
        dir_tbl[11] = {1'b1, OP_BYTE, 8'h32, QUIET};
        dir_tbl[12] = {1'b1, OP_BYTE, 8'h33, QUIET};
        dir_tbl[13] = {1'b1, OP_BYTE, 8'h34, QUIET};
        dir_tbl[14] = {1'b1, OP_BYTE, 8'h35, QUIET};
        dir_tbl[15] = {1'b1, OP_BYTE, 8'h36, DENIED};
        dir_tbl[16] = {1'b0, OP_BYTE, CHAR_CHECK, QUIET};
        dir_tbl[17] = {1'b0, OP_BYTE, 8'hFF, QUIET};
        dir_tbl[18] = {1'b0, OP_BYTE, 8'h32, QUIET};
        dir_tbl[19] = {1'b0, OP_BYTE, 8'h33, QUIET};
        dir_tbl[20] = {1'b0, OP_BYTE, CHAR_ENTER, QUIET};  // switch mode mid-password
        dir_tbl[21] = {1'b0, OP_BYTE, 8'h34, QUIET};
        dir_tbl[22] = {1'b0, OP_BYTE, 8'h35, QUIET};
        dir_tbl[23] = {1'b0, OP_BYTE, 8'h00, QUIET};
        dir_tbl[24] = {1'b0, OP_TICK, 8'hFF, QUIET};

        tx_idle_pct = 24;
        rx_idle_pct <= 53;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < 25; k++)
            send_item(dir_tbl[k].item, dir_tbl[k].known, dir_tbl[k].want);

        // hold the result side long enough to back up the input
        hold_req <= hold_req + 1;
        run_random(90);

        run_phase(8'd1, 4'd1, 4'd2, '0, 24, 53, 90);
        run_phase(8'd255, 4'd14, 4'd15, {PW_W{1'b1}}, 53, 24, 90);
        run_phase(8'd0, 4'd15, 4'd1, PW_W'({$urandom, $urandom}), 53, 24, 80);
        run_phase(8'd2, 4'd0, 4'd0, '0, 0, 0, 80);
        trav = 4'($urandom_range(6, 1));
        run_phase(8'($urandom_range(8, 1)), trav, 4'($urandom_range(15, trav + 1)),
                  PW_W'({$urandom, $urandom}), 0, 0, 100);

        wait_idle();
        if (errors == 0)
            $display("[password_door_lock_controller] OK");
        else
            $display("[password_door_lock_controller] ERROR");
        $finish;
    end
endmodule
`default_nettype wire

>>> password_door_lock_controller.f
src/pdlc_pkg.sv
src/password_door_lock_controller.sv
src/pdlc_checker.sv
tb/password_door_lock_controller_test.sv
